// ===== src/lqim_pkg.sv =====
// ----------------------------------------------------------------------------
// lqim_pkg: shared types and table for the log quantizer index mapper
// Holds the Q4 quantizer table, payload structs and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lqim_pkg;

    localparam int NUM_CODES      = 64;
    localparam int IDX_W          = 6;
    localparam int CODED_W        = 8;
    localparam int QUANT_W        = 20;
    localparam int TBL_W          = 13;
    localparam int SUM_W          = TBL_W + 1;
    localparam int QSHIFT_DEF     = 4;

    // command codes
    localparam logic CMD_TO_QUANT = 1'b0;
    localparam logic CMD_TO_INDEX = 1'b1;

    typedef logic [TBL_W-1:0] t_tbl_entry;

    // log-spaced quantizer values in Q4, entry 0 is lossless
    localparam t_tbl_entry QMAP_Q4 [0:NUM_CODES-1] = '{
        13'h0000,
        13'h0009, 13'h000A, 13'h000B, 13'h000C, 13'h000D, 13'h000F,
        13'h0011, 13'h0013, 13'h0015, 13'h0018, 13'h001B, 13'h001E,
        13'h0021, 13'h0024, 13'h0029, 13'h002E, 13'h0034, 13'h003A,
        13'h0041, 13'h0048, 13'h0051, 13'h005A, 13'h0064, 13'h0070,
        13'h007D, 13'h008C, 13'h009C, 13'h00AE, 13'h00C3, 13'h00D9,
        13'h00F3, 13'h010F, 13'h012F, 13'h0152, 13'h0179, 13'h01A5,
        13'h01D6, 13'h020D, 13'h0249, 13'h028E, 13'h02DA, 13'h032E,
        13'h038D, 13'h03F7, 13'h046D, 13'h04F0, 13'h0583, 13'h0627,
        13'h06DE, 13'h07AA, 13'h088E, 13'h098D, 13'h0AA9, 13'h0BE6,
        13'h0D48, 13'h0ED3, 13'h108C, 13'h1278, 13'h149D, 13'h1702,
        13'h19AE, 13'h1CAA, 13'h1FFF
    };

    typedef struct packed {
        logic               command;
        logic [CODED_W-1:0] coded_index;
        logic [QUANT_W-1:0] quantizer_in;
    } t_req;

    typedef struct packed {
        logic [QUANT_W-1:0] quantizer_out;
        logic [IDX_W-1:0]   index_out;
    } t_rsp;

    // twice the midpoint between entry i and entry i+1
    function automatic logic [SUM_W-1:0] mid_sum(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] nxt;
        nxt = i + IDX_W'(1);
        return {1'b0, QMAP_Q4[i]} + {1'b0, QMAP_Q4[nxt]};
    endfunction

endpackage

`default_nettype wire

// ===== src/lqim_stream_if.sv =====
// ----------------------------------------------------------------------------
// lqim_stream_if: valid/ready channel
// Carries one payload per transaction, source drives valid and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lqim_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/lqim_map.sv =====
// ----------------------------------------------------------------------------
// lqim_map: combinational index/quantizer mapping
// Forward lookup with clamp, inverse nearest-entry search by midpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module lqim_map #(
    parameter int QSHIFT = lqim_pkg::QSHIFT_DEF
) (
    input  wire  lqim_pkg::t_req i_req,
    output lqim_pkg::t_rsp       o_rsp
);
    localparam int SHIFT_DIFF = QSHIFT - 4;
    localparam int IDX_W      = lqim_pkg::IDX_W;
    localparam int QUANT_W    = lqim_pkg::QUANT_W;
    localparam int NC         = lqim_pkg::NUM_CODES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NC - 1);

    logic [IDX_W-1:0]   fwd_idx;
    logic [QUANT_W-1:0] fwd_quant;
    logic [QUANT_W-1:0] q4;
    logic [QUANT_W:0]   q4_x2;
    logic [NC-1:0]      above_mid;
    logic [IDX_W-1:0]   inv_idx;

    // clamp the coded index and scale the table value to the coefficient shift
    always_comb begin
        if (i_req.coded_index > lqim_pkg::CODED_W'(NC - 1)) begin
            fwd_idx = LAST_IDX;
        end else begin
            fwd_idx = i_req.coded_index[IDX_W-1:0];
        end
        fwd_quant = QUANT_W'(lqim_pkg::QMAP_Q4[fwd_idx]) << SHIFT_DIFF;
    end

    // flag each midpoint from entry 1 upward that the value lies above
    always_comb begin
        q4            = i_req.quantizer_in >> SHIFT_DIFF;
        q4_x2         = {q4, 1'b0};
        above_mid     = '0;
        for (int i = 1; i < NC - 1; i++) begin
            above_mid[i] = q4_x2 > (QUANT_W+1)'(lqim_pkg::mid_sum(IDX_W'(i)));
        end
    end

    // encode the thermometer edge into the nearest index; ties stay low
    always_comb begin
        inv_idx = '0;
        for (int k = 1; k < NC; k++) begin
            if (above_mid[k-1] == (k > 1) && !above_mid[k]) begin
                inv_idx = inv_idx | IDX_W'(k);
            end
        end
    end

    // select the result for the command; unused field reads zero
    always_comb begin
        o_rsp = '0;
        if (i_req.command == lqim_pkg::CMD_TO_QUANT) begin
            if (i_req.coded_index != '0) begin
                o_rsp.quantizer_out = fwd_quant;
            end
        end else begin
            if (i_req.quantizer_in != '0) begin
                o_rsp.index_out = inv_idx;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/log_quantizer_index_mapper.sv =====
// ----------------------------------------------------------------------------
// log_quantizer_index_mapper: log-spaced quantizer index mapper
// Maps coded indices to quantizers and quantizers to the nearest index.
// ----------------------------------------------------------------------------
//
//  channel   direction   payload                                     role
//  i_req     sink        command, coded_index, quantizer_in          request
//  o_rsp     source      quantizer_out, index_out                    result
//
// One transaction per cycle while results are taken. A request passes through
// the input register, the mapping logic and the result register. The 62
// midpoint comparators of the inverse search set the logic depth.
// Reset clears the valid flags only. A stalled result holds its register; the
// input register takes one more transaction while it is empty, then holds.
// ----------------------------------------------------------------------------
`default_nettype none

module log_quantizer_index_mapper #(
    parameter int QSHIFT = lqim_pkg::QSHIFT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    lqim_stream_if.sink         i_req,
    lqim_stream_if.source       o_rsp
);
    lqim_pkg::t_req r_req;
    logic           r_req_valid;
    lqim_pkg::t_rsp r_rsp;
    logic           r_rsp_valid;
    lqim_pkg::t_rsp n_rsp;
    logic           adv_rsp;
    logic           adv_req;

    // advance each stage when the one after it has room
    assign adv_rsp     = !r_rsp_valid || o_rsp.ready;
    assign adv_req     = !r_req_valid || adv_rsp;
    assign i_req.ready = adv_req;

    // hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (adv_req) begin
            r_req_valid <= i_req.valid;
        end
        if (adv_req && i_req.valid) begin
            r_req <= i_req.payload;
        end
    end

    lqim_map #(
        .QSHIFT (QSHIFT)
    ) u_map (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    // register the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (adv_rsp) begin
            r_rsp_valid <= r_req_valid;
        end
        if (adv_rsp && r_req_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire
